### design/blac_pkg.sv
// ----------------------------------------------------------------------------
// blac_pkg
// Shared types and constants for the bigram line absence counter: table
// size, queue depth and the command word passed from front to back.
// ----------------------------------------------------------------------------
package blac_pkg;

	// table geometry
	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// field widths
	localparam int CFG_W   = 7;
	localparam int SLOT_W  = 6;
	localparam int PAIR_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 32;

	// register reset value
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd32;

	// command queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command word: a table load or one classified text byte
	typedef struct packed {
		logic              is_load;
		logic [IDX_W-1:0]  slot;
		logic [PAIR_W-1:0] pair;     // load value or adjacent byte pair
		logic              pair_ok;  // pair holds two bytes of the line
		logic              eol;
	} cmd_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		ST_RUN    = 2'b01,
		ST_REPORT = 2'b10
	} back_state_t;

endpackage

### design/blac_queue.sv
// ----------------------------------------------------------------------------
// blac_queue
// Small command queue between the front and back ends so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module blac_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  blac_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output blac_pkg::cmd_t pop_cmd,
	output logic          not_empty
);
	import blac_pkg::*;

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/blac_front.sv
// ----------------------------------------------------------------------------
// blac_front
// Input side: accepts words, drops loads to slots outside the table, and
// pairs each text byte with the previous byte of the same line.
// ----------------------------------------------------------------------------
module blac_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [blac_pkg::SLOT_W-1:0]  entry_index,
	input  logic [blac_pkg::PAIR_W-1:0]  bigram_value,
	input  logic [blac_pkg::BYTE_W-1:0]  text_byte,
	input  logic                         end_of_line,
	output logic                         push,
	output blac_pkg::cmd_t               push_cmd,
	input  logic                         full
);
	import blac_pkg::*;

	logic [BYTE_W-1:0] prev_byte_q;
	logic              have_prev_q;
	logic              accept;
	logic              slot_ok;

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;
	assign slot_ok  = ({1'b0, entry_index} < (SLOT_W + 1)'(MAX_ENTRIES));

	// classify the word; out-of-table loads are dropped here
	always_comb begin
		push_cmd         = '0;
		push_cmd.is_load = !mode;
		push_cmd.slot    = IDX_W'(entry_index);
		push_cmd.eol     = mode && end_of_line;
		push_cmd.pair_ok = mode && have_prev_q;
		push_cmd.pair    = mode ? {prev_byte_q, text_byte} : bigram_value;
		push             = accept && (mode || slot_ok);
	end

	// previous byte of the current line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q <= '0;
			have_prev_q <= 1'b0;
		end else if (accept && mode) begin
			prev_byte_q <= end_of_line ? '0 : text_byte;
			have_prev_q <= !end_of_line;
		end
	end

endmodule

### design/blac_back.sv
// ----------------------------------------------------------------------------
// blac_back
// Execution side: holds the bigram table, seen marks and absence counters,
// matches pairs against every slot in use at once, and walks those slots
// at the end of each line to emit one report per slot.
// ----------------------------------------------------------------------------
module blac_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [blac_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                          cmd_valid,
	input  blac_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [blac_pkg::SLOT_W-1:0]   report_entry,
	output logic [blac_pkg::COUNT_W-1:0]  report_line,
	output logic                          bigram_present,
	output logic [blac_pkg::COUNT_W-1:0]  absent_count,
	output logic                          last_report
);
	import blac_pkg::*;

	localparam logic [COUNT_W-1:0] SAT = '1;

	back_state_t        state_q;
	logic [CFG_W-1:0]   entries_q;
	logic [PAIR_W-1:0]  pairs_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] seen_q;
	logic [COUNT_W-1:0] absent_q [MAX_ENTRIES];
	logic [COUNT_W-1:0] line_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;

	logic [CNT_W-1:0]   n_act;
	logic [IDX_W-1:0]   last_idx;
	logic               out_free;
	logic               rep_step;
	logic               rep_last;
	logic [COUNT_W-1:0] cur_cnt;
	logic [COUNT_W-1:0] next_cnt;
	logic [MAX_ENTRIES-1:0] hit;

	// slots in use, clamped to 1..MAX_ENTRIES
	always_comb begin
		if (entries_q == '0) begin
			n_act = CNT_W'(1);
		end else if (entries_q > CFG_W'(MAX_ENTRIES)) begin
			n_act = CNT_W'(MAX_ENTRIES);
		end else begin
			n_act = CNT_W'(entries_q);
		end
	end
	assign last_idx = IDX_W'(n_act - 1'b1);

	// entries_in_use register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (cfg_wr_en) begin
			entries_q <= cfg_wr_data;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign cmd_pop  = cmd_valid && (state_q == ST_RUN);
	assign rep_step = (state_q == ST_REPORT) && out_free;
	assign rep_last = (idx_q == last_idx);

	// per-slot compare against the incoming pair
	always_comb begin
		for (int k = 0; k < MAX_ENTRIES; k++) begin
			hit[k] = (CNT_W'(k) < n_act) && (pairs_q[k] == cmd.pair);
		end
	end

	// saturating count for the slot being reported
	assign cur_cnt  = absent_q[idx_q];
	assign next_cnt = (!seen_q[idx_q] && cur_cnt != SAT) ? cur_cnt + 1'b1 : cur_cnt;

	// bigram table, no reset
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.is_load) begin
			pairs_q[cmd.slot] <= cmd.pair;
		end
	end

	// sequencer, seen marks, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			seen_q  <= '0;
			line_q  <= '0;
			idx_q   <= '0;
			for (int k = 0; k < MAX_ENTRIES; k++) begin
				absent_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (cmd_pop) begin
						if (cmd.is_load) begin
							seen_q[cmd.slot]   <= 1'b0;
							absent_q[cmd.slot] <= '0;
						end else begin
							if (cmd.pair_ok) begin
								seen_q <= seen_q | hit;
							end
							if (cmd.eol) begin
								state_q <= ST_REPORT;
								idx_q   <= '0;
							end
						end
					end
				end
				ST_REPORT: begin
					if (rep_step) begin
						absent_q[idx_q] <= next_cnt;
						if (rep_last) begin
							seen_q  <= '0;
							state_q <= ST_RUN;
							if (line_q != SAT) begin
								line_q <= line_q + 1'b1;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= rep_step;
		end
	end

	always_ff @(posedge clk) begin
		if (rep_step) begin
			report_entry   <= SLOT_W'(idx_q);
			report_line    <= line_q;
			bigram_present <= seen_q[idx_q];
			absent_count   <= next_cnt;
			last_report    <= rep_last;
		end
	end

	assign out_valid = out_valid_q;

	// end of a report pass leaves all marks clear and the sequencer running
	a_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_step && rep_last) |=> (seen_q == '0 && state_q == ST_RUN))
		else $error("report pass did not clear marks");

	// report walk stays inside the slots in use
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT) |-> (idx_q <= last_idx))
		else $error("report index beyond slots in use");

	// no command is taken while a report pass runs
	a_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT) |-> !cmd_pop)
		else $error("command popped during report pass");

	// an absence count never exceeds the line index plus one
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, absent_count} <= {1'b0, report_line} + 1'b1))
		else $error("absence count exceeds lines seen");

endmodule

### design/bigram_line_absence_counter.sv
// ----------------------------------------------------------------------------
// bigram_line_absence_counter
// Tracks a table of byte bigrams and, per text line, reports for each slot
// in use whether the line held the bigram and how many lines lacked it.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | mode, entry_index, bigram_value,
//          |                      | text_byte, end_of_line
//  out     | out_valid / out_stall| report_entry, report_line, bigram_present,
//          |                      | absent_count, last_report
//  cfg     | cfg_wr_en            | cfg_wr_data (entries_in_use)
//
// Loads and text bytes are taken one per cycle while the 4-word command
// queue has room; the back end executes one command per cycle outside a
// report pass. An end-of-line byte starts a report pass over the slots in
// use, one report per cycle through the output register while out_stall
// allows; the queue fills during the pass.
// Reset clears counters, marks and the line index at once; no sweep.
// out_stall holds the pass; in_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module bigram_line_absence_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [blac_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [blac_pkg::SLOT_W-1:0]   entry_index,
	input  logic [blac_pkg::PAIR_W-1:0]   bigram_value,
	input  logic [blac_pkg::BYTE_W-1:0]   text_byte,
	input  logic                          end_of_line,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [blac_pkg::SLOT_W-1:0]   report_entry,
	output logic [blac_pkg::COUNT_W-1:0]  report_line,
	output logic                          bigram_present,
	output logic [blac_pkg::COUNT_W-1:0]  absent_count,
	output logic                          last_report
);
	import blac_pkg::*;

	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic push;
	logic full;
	logic pop;
	logic not_empty;

	// front end: accept and classify
	blac_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.entry_index  (entry_index),
		.bigram_value (bigram_value),
		.text_byte    (text_byte),
		.end_of_line  (end_of_line),
		.push         (push),
		.push_cmd     (push_cmd),
		.full         (full)
	);

	// command queue
	blac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (not_empty)
	);

	// back end: match, count, report
	blac_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd_valid      (not_empty),
		.cmd            (pop_cmd),
		.cmd_pop        (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.report_entry   (report_entry),
		.report_line    (report_line),
		.bigram_present (bigram_present),
		.absent_count   (absent_count),
		.last_report    (last_report)
	);

endmodule

### verif/blac_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blac_tb_pkg
// Input word codes shared by the bigram line absence counter testbench
// and its checker.
// ----------------------------------------------------------------------------
package blac_tb_pkg;

	// meaning of the mode field of an input word
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TEXT = 1'b1;

endpackage

### verif/bigram_line_absence_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bigram_line_absence_checker
// Watches the input, output and register ports of the bigram line absence
// counter, keeps its own copy of the bigram table, seen marks and absence
// counters, builds the reports each end-of-line byte should produce and
// compares every accepted report word with the oldest one still due.
// ----------------------------------------------------------------------------
module bigram_line_absence_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [blac_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          mode,
	input  logic [blac_pkg::SLOT_W-1:0]   entry_index,
	input  logic [blac_pkg::PAIR_W-1:0]   bigram_value,
	input  logic [blac_pkg::BYTE_W-1:0]   text_byte,
	input  logic                          end_of_line,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [blac_pkg::SLOT_W-1:0]   report_entry,
	input  logic [blac_pkg::COUNT_W-1:0]  report_line,
	input  logic                          bigram_present,
	input  logic [blac_pkg::COUNT_W-1:0]  absent_count,
	input  logic                          last_report,
	output int                            errors,
	output int                            pending
);
	import blac_pkg::*;
	import blac_tb_pkg::*;

	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic [SLOT_W-1:0]  entry;
		logic [COUNT_W-1:0] line_idx;
		logic               present;
		logic [COUNT_W-1:0] absent;
		logic               last;
	} line_report_t;

	// reports still owed by the block, oldest first
	line_report_t       due_reports[$];

	// shadow of the block state
	logic [PAIR_W-1:0]  pair_table [MAX_ENTRIES];
	logic               seen_now   [MAX_ENTRIES];
	logic [COUNT_W-1:0] miss_count [MAX_ENTRIES];
	logic [BYTE_W-1:0]  last_byte;
	logic               have_last;
	logic [COUNT_W-1:0] line_no;
	logic [CFG_W-1:0]   slots_cfg;

	// back to the post-reset state
	task automatic clear_shadow();
		for (int k = 0; k < MAX_ENTRIES; k++) begin
			pair_table[k] = '0;
			seen_now[k]   = 1'b0;
			miss_count[k] = '0;
		end
		last_byte = '0;
		have_last = 1'b0;
		line_no   = '0;
		slots_cfg = ENTRIES_RESET;
		due_reports.delete();
		errors = 0;
	endtask

	// advance the shadow by one input word, queueing any reports it causes
	task automatic apply_word(input logic md, input logic [SLOT_W-1:0] idx,
			input logic [PAIR_W-1:0] pv, input logic [BYTE_W-1:0] b, input logic eol);
		int           act;
		line_report_t r;
		// zero means one slot, anything past the table means the whole table
		act = (slots_cfg == 0) ? 1 : (slots_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(slots_cfg);
		if (md == MODE_LOAD) begin
			// slots past the table are dropped
			if (idx < MAX_ENTRIES) begin
				pair_table[idx] = pv;
				seen_now[idx]   = 1'b0;
				miss_count[idx] = '0;
			end
		end else begin
			// mark every slot in use that holds the pair just formed
			if (have_last) begin
				for (int k = 0; k < act; k++) begin
					if (pair_table[k] == {last_byte, b})
						seen_now[k] = 1'b1;
				end
			end
			last_byte = b;
			have_last = 1'b1;
			if (eol) begin
				// one report per slot in use, counts saturate
				for (int k = 0; k < act; k++) begin
					if (!seen_now[k] && miss_count[k] != '1)
						miss_count[k] = miss_count[k] + 1'b1;
					r.entry    = SLOT_W'(k);
					r.line_idx = line_no;
					r.present  = seen_now[k];
					r.absent   = miss_count[k];
					r.last     = (k + 1 == act);
					due_reports = {due_reports, r};
				end
				for (int k = 0; k < MAX_ENTRIES; k++)
					seen_now[k] = 1'b0;
				have_last = 1'b0;
				last_byte = '0;
				if (line_no != '1)
					line_no = line_no + 1'b1;
			end
		end
	endtask

	// compare one accepted report word with the oldest one due
	task automatic check_report();
		line_report_t want;
		if (due_reports.size() == 0) begin
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("unexpected report: entry %0d line %0d present %0b absent %0d last %0b",
					report_entry, report_line, bigram_present, absent_count, last_report);
		end else begin
			want = due_reports.pop_front();
			if (report_entry !== want.entry || report_line !== want.line_idx ||
					bigram_present !== want.present || absent_count !== want.absent ||
					last_report !== want.last) begin
				errors++;
				if (errors <= SHOW_LIMIT) begin
					$display("report mismatch: expected entry %0d line %0d present %0b absent %0d last %0b",
						want.entry, want.line_idx, want.present, want.absent, want.last);
					$display("                 actual   entry %0d line %0d present %0b absent %0d last %0b",
						report_entry, report_line, bigram_present, absent_count, last_report);
				end
			end
		end
	endtask

	// sample all three ports at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_shadow();
		end else begin
			if (out_valid && !out_stall)
				check_report();
			if (cfg_wr_en)
				slots_cfg = cfg_wr_data;
			if (in_valid && !in_stall)
				apply_word(mode, entry_index, bigram_value, text_byte, end_of_line);
		end
		pending = due_reports.size();
	end

endmodule

### verif/bigram_line_absence_counter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bigram_line_absence_counter_test
// Loads the bigram table, streams directed and random text lines through the
// counter under several slot counts, with bursty input, random output stalls
// and one long output hold-off, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module bigram_line_absence_counter_test;
	import blac_pkg::*;
	import blac_tb_pkg::*;

	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [CFG_W-1:0]   cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic [SLOT_W-1:0]  entry_index;
	logic [PAIR_W-1:0]  bigram_value;
	logic [BYTE_W-1:0]  text_byte;
	logic               end_of_line;
	logic               out_valid;
	logic               out_stall;
	logic [SLOT_W-1:0]  report_entry;
	logic [COUNT_W-1:0] report_line;
	logic               bigram_present;
	logic [COUNT_W-1:0] absent_count;
	logic               last_report;
	int                 errors;
	int                 pending;

	// sender and receiver bookkeeping
	logic [PAIR_W-1:0]  slot_pair [MAX_ENTRIES];
	int                 burst_left = 0;
	int                 items_sent = 0;
	bit                 gaps_on    = 1'b0;
	bit                 hold_req   = 1'b0;

	bigram_line_absence_counter u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.entry_index    (entry_index),
		.bigram_value   (bigram_value),
		.text_byte      (text_byte),
		.end_of_line    (end_of_line),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.report_entry   (report_entry),
		.report_line    (report_line),
		.bigram_present (bigram_present),
		.absent_count   (absent_count),
		.last_report    (last_report)
	);

	bigram_line_absence_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.entry_index    (entry_index),
		.bigram_value   (bigram_value),
		.text_byte      (text_byte),
		.end_of_line    (end_of_line),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.report_entry   (report_entry),
		.report_line    (report_line),
		.bigram_present (bigram_present),
		.absent_count   (absent_count),
		.last_report    (last_report),
		.errors         (errors),
		.pending        (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// present one word, called and returning at a falling edge
	task automatic send_word(input logic md, input logic [SLOT_W-1:0] idx,
			input logic [PAIR_W-1:0] pv, input logic [BYTE_W-1:0] b, input logic eol);
		// end of a burst: drop valid for a random gap when gaps are on
		if (burst_left == 0) begin
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		mode         <= md;
		entry_index  <= idx;
		bigram_value <= pv;
		text_byte    <= b;
		end_of_line  <= eol;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	// table load, byte and line fields carry noise
	task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [PAIR_W-1:0] pv);
		send_word(MODE_LOAD, slot, pv, BYTE_W'($urandom), 1'($urandom));
		if (slot < MAX_ENTRIES)
			slot_pair[slot] = pv;
	endtask

	// load to any slot, in or past the table, often with a pair already tracked
	task automatic random_load();
		logic [PAIR_W-1:0] pv;
		pv = $urandom_range(1) ? PAIR_W'($urandom) : slot_pair[$urandom_range(MAX_ENTRIES - 1)];
		load_slot(SLOT_W'($urandom_range(63)), pv);
	endtask

	// text byte, slot and pair fields carry noise
	task automatic send_text(input logic [BYTE_W-1:0] b, input logic eol);
		send_word(MODE_TEXT, SLOT_W'($urandom), PAIR_W'($urandom), b, eol);
	endtask

	// one full line, with the odd load slipped in between its bytes
	task automatic send_line(input logic [BYTE_W-1:0] bytes_q[$]);
		for (int i = 0; i < bytes_q.size(); i++) begin
			if (i > 0 && $urandom_range(19) == 0)
				random_load();
			send_text(bytes_q[i], i == bytes_q.size() - 1);
		end
	endtask

	// line built mostly from tracked pairs and their halves
	task automatic random_line();
		logic [BYTE_W-1:0] bytes_q[$];
		int                len;
		int                s;
		len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
		while (bytes_q.size() < len) begin
			s = $urandom_range(MAX_ENTRIES - 1);
			case ($urandom_range(3))
				0, 1: begin
					bytes_q = {bytes_q, slot_pair[s][15:8]};
					bytes_q = {bytes_q, slot_pair[s][7:0]};
				end
				2: bytes_q = {bytes_q, slot_pair[s][7:0]};
				default: bytes_q = {bytes_q, BYTE_W'($urandom_range(255))};
			endcase
		end
		send_line(bytes_q);
	endtask

	task automatic random_phase(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(9) == 0)
				random_load();
			else
				random_line();
		end
	endtask

	// stop sending and wait out every report still due
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// receiver: random stall segments, one long hold-off on request
	initial begin : receiver
		int seg_len;
		int pct;
		bit hold_taken;
		hold_taken = 1'b0;
		out_stall  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				seg_len = $urandom_range(8, 120);
				case ($urandom_range(3))
					0: pct = 0;
					1: pct = 20;
					2: pct = 50;
					default: pct = 85;
				endcase
				repeat (seg_len) begin
					@(negedge clk);
					out_stall <= ($urandom_range(99) < pct);
					if (hold_req && !hold_taken)
						break;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL bigram_line_absence_counter");
		$finish;
	end

	// stimulus and verdict
	initial begin : stimulus
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		in_valid     = 1'b0;
		mode         = MODE_LOAD;
		entry_index  = '0;
		bigram_value = '0;
		text_byte    = '0;
		end_of_line  = 1'b0;
		for (int k = 0; k < MAX_ENTRIES; k++)
			slot_pair[k] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill the whole table under the reset slot count, edge pairs first
		load_slot(6'd0, 16'h0000);
		load_slot(6'd1, 16'hFFFF);
		load_slot(6'd2, 16'h00FF);
		load_slot(6'd3, 16'hFF00);
		load_slot(6'd4, 16'h4142);
		load_slot(6'd5, 16'h4142);
		load_slot(6'd6, 16'h4241);
		for (int k = 7; k < MAX_ENTRIES; k++)
			load_slot(SLOT_W'(k), PAIR_W'($urandom));
		// loads past the table are dropped
		load_slot(6'd63, 16'h4141);
		load_slot(6'd32, 16'h4141);

		// single-byte line: nothing present
		send_line('{8'h00});
		send_line('{8'h00, 8'h00});
		send_line('{8'hFF, 8'hFF, 8'h00});
		send_line('{8'h00, 8'hFF});
		send_line('{8'h41, 8'h42, 8'h41});
		// reload mid-line: the line goes on, the slot starts over
		send_text(8'h42, 1'b0);
		load_slot(6'd6, 16'h4243);
		send_text(8'h43, 1'b1);
		// first byte of a line never pairs with the last byte of the one before
		send_line('{8'h41});
		send_line('{8'h42, 8'h41});
		drain();

		// zero acts as one slot
		write_cfg(7'd0);
		gaps_on = 1'b1;
		random_phase(25);
		drain();

		// above the table acts as the full table; long output hold-off here
		write_cfg(7'd127);
		hold_req = 1'b1;
		random_phase(25);
		drain();

		write_cfg(7'd1);
		gaps_on = 1'b0;
		random_phase(20);
		drain();

		write_cfg(7'd32);
		gaps_on = 1'b1;
		random_phase(25);
		drain();

		write_cfg(7'd64);
		random_phase(20);
		drain();

		write_cfg(CFG_W'($urandom_range(2, MAX_ENTRIES - 1)));
		random_phase(20);
		drain();

		write_cfg(CFG_W'($urandom_range(2, MAX_ENTRIES - 1)));
		random_phase(25);
		drain();

		if (errors == 0 && pending == 0)
			$display("PASS bigram_line_absence_counter");
		else
			$display("FAIL bigram_line_absence_counter");
		$finish;
	end

endmodule
